/* hw/rtl/sha_pkg.sv */
package sha_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic        misuse_error;
	} rsp_t;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;
	localparam logic [7:0] PAD_MARK = 8'h80;

	typedef struct packed {
		logic       load_byte;
		logic       pad_shift;
		logic       pad_first;
		logic       pad_len;
		logic       init_v;
		logic       round_en;
		logic [5:0] rnd;
		logic       add_hash;
		logic       err;
		logic [2:0] widx;
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
	} sts_t;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

/* hw/rtl/sha256_stream_hasher_core.sv */
// Data item: taken while idle; every 64th byte adds a block compression
// (64 rounds, one per cycle, then the hash update) during which no item is taken.
// Finish item: padding goes in at one byte per cycle up to the block end, then one or
// two compressions, then eight digest items at one per cycle as the sink takes them.
// Item after finish: one error item, next cycle.
// Reset: hash words to the initial values, byte counters cleared, ready for a new message.
module sha256_stream_hasher_core
	import sha_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_kind  (req.kind),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sha_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (req.data_byte),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

/* hw/rtl/sha_ctrl.sv */
module sha_ctrl
	import sha_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  logic req_kind,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PAD  = 6'b000010,
		S_COMP = 6'b000100,
		S_ADD  = 6'b001000,
		S_EMIT = 6'b010000,
		S_ERR  = 6'b100000
	} state_t;

	state_t     state_q;
	logic [5:0] rnd_q;
	logic [2:0] widx_q;
	logic       done_q;
	logic       fin_q;
	logic       extra_q;
	logic       first_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_EMIT) || (state_q == S_ERR);

	always_comb begin
		cmd = '0;
		cmd.rnd = rnd_q;
		cmd.widx = widx_q;
		cmd.err = (state_q == S_ERR);
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && !done_q && req_kind == KIND_DATA) begin
					cmd.load_byte = 1'b1;
					cmd.init_v = (sts.fill == 6'd63);
				end
			end
			S_PAD: begin
				cmd.pad_shift = 1'b1;
				cmd.pad_first = first_q;
				cmd.pad_len = !first_q && !extra_q && (sts.fill[5:3] == 3'd7);
				cmd.init_v = (sts.fill == 6'd63);
			end
			S_COMP: cmd.round_en = 1'b1;
			S_ADD:  cmd.add_hash = 1'b1;
			S_EMIT: ;
			S_ERR:  ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rnd_q <= '0;
			widx_q <= '0;
			done_q <= 1'b0;
			fin_q <= 1'b0;
			extra_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (done_q) begin
							state_q <= S_ERR;
						end else if (req_kind == KIND_DATA) begin
							if (sts.fill == 6'd63) begin
								state_q <= S_COMP;
								rnd_q <= '0;
							end
						end else begin
							state_q <= S_PAD;
							fin_q <= 1'b1;
							first_q <= 1'b1;
							extra_q <= (sts.fill[5:3] == 3'd7);
						end
					end
				end
				S_PAD: begin
					first_q <= 1'b0;
					if (sts.fill == 6'd63) begin
						state_q <= S_COMP;
						rnd_q <= '0;
					end
				end
				S_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					if (!fin_q) begin
						state_q <= S_IDLE;
					end else if (extra_q) begin
						extra_q <= 1'b0;
						state_q <= S_PAD;
					end else begin
						done_q <= 1'b1;
						widx_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (rsp_ready) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == 3'd7) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ERR: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/sha_dp.sv */
module sha_dp
	import sha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  cmd_t       cmd,
	output sts_t       sts,
	output rsp_t       rsp
);

	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [60:0]  total_q;
	logic [31:0]  hash_q [8];
	logic [31:0]  v_q [8];

	logic [63:0]  bits;
	logic [7:0]   pad_byte;
	logic [7:0]   shift_byte;
	logic [31:0]  w0, w1, w9, w14, w_new;
	logic [31:0]  s0, s1, big0, big1, ch, maj, t1, t2;

	assign sts.fill = fill_q;
	assign bits = {total_q, 3'b000};

	always_comb begin
		priority if (cmd.pad_first) begin
			pad_byte = PAD_MARK;
		end else if (cmd.pad_len) begin
			pad_byte = bits[8 * (7 - {29'd0, fill_q[2:0]}) +: 8];
		end else begin
			pad_byte = 8'h00;
		end
		shift_byte = cmd.load_byte ? data_byte : pad_byte;
	end

	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];
	assign s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
	assign s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
	assign w_new = w0 + s0 + w9 + s1;

	assign big1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
	assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign big0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
	assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + big1 + ch + ROUND_K[cmd.rnd] + w0;
	assign t2 = big0 + maj;

	always_ff @(posedge clk) begin
		if (cmd.load_byte || cmd.pad_shift) begin
			blk_q <= {blk_q[503:0], shift_byte};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (cmd.init_v) begin
			v_q <= hash_q;
		end else if (cmd.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			total_q <= '0;
			hash_q <= INIT_H;
		end else begin
			if (cmd.load_byte || cmd.pad_shift) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.load_byte) begin
				total_q <= total_q + 61'd1;
			end
			if (cmd.add_hash) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + v_q[i];
				end
			end
		end
	end

	always_comb begin
		if (cmd.err) begin
			rsp.digest_word = '0;
			rsp.word_index = '0;
			rsp.last_word = 1'b1;
			rsp.misuse_error = 1'b1;
		end else begin
			rsp.digest_word = hash_q[cmd.widx];
			rsp.word_index = cmd.widx;
			rsp.last_word = (cmd.widx == 3'd7);
			rsp.misuse_error = 1'b0;
		end
	end

endmodule

/* dv/sha256_stream_hasher_core_test.sv */
`timescale 1ns / 100ps

module sha256_stream_hasher_core_test;
	import sha_pkg::*;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] H_START [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	sha256_stream_hasher_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	req_t pending_q[$];
	rsp_t digest_q[$];
	int item_total;
	int issued_cnt;
	int taken_cnt;
	int word_cnt;
	int words_seen;
	int send_gap;
	int sink_stall;
	bit send_burst;
	bit sink_burst;
	int errors;

	logic [31:0] hash_w[8];
	logic [7:0] blk[64];
	logic [5:0] fill;
	logic [60:0] byte_cnt;
	bit finished;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w[64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		{a, b, c, d, e, f, g, h} = {hash_w[0], hash_w[1], hash_w[2], hash_w[3],
			hash_w[4], hash_w[5], hash_w[6], hash_w[7]};
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ K_TAB[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_w[0] += a; hash_w[1] += b; hash_w[2] += c; hash_w[3] += d;
		hash_w[4] += e; hash_w[5] += f; hash_w[6] += g; hash_w[7] += h;
	endtask

	task automatic predict_digest(input req_t it);
		logic [63:0] bits;
		int pos;
		rsp_t r;
		if (finished) begin
			r = '0;
			r.last_word = 1'b1;
			r.misuse_error = 1'b1;
			digest_q.push_back(r);
		end else if (it.kind == KIND_DATA) begin
			blk[fill] = it.data_byte;
			byte_cnt = byte_cnt + 61'd1;
			fill = fill + 6'd1;
			if (fill == 6'd0)
				compress();
		end else begin
			bits = {byte_cnt, 3'b000};
			pos = int'(fill);
			blk[pos++] = PAD_MARK;
			if (pos > 56) begin
				while (pos < 64)
					blk[pos++] = 8'h00;
				compress();
				pos = 0;
			end
			while (pos < 56)
				blk[pos++] = 8'h00;
			for (int i = 0; i < 8; i++)
				blk[56+i] = bits[63-8*i -: 8];
			compress();
			fill = '0;
			finished = 1'b1;
			for (int i = 0; i < 8; i++) begin
				r.digest_word = hash_w[i];
				r.word_index = 3'(i);
				r.last_word = (i == 7);
				r.misuse_error = 1'b0;
				digest_q.push_back(r);
			end
		end
	endtask

	function automatic req_t mk(input logic k, input logic [7:0] b);
		req_t it;
		it.kind = k;
		it.data_byte = b;
		return it;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("sha256_stream_hasher_core_test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (req_valid && req_ready) begin
			predict_digest(req);
			taken_cnt <= taken_cnt + 1;
		end
		if (rsp_valid && rsp_ready) begin
			word_cnt <= word_cnt + 1;
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected item %h", $time, rsp);
				errors++;
			end else begin
				if (rsp.digest_word !== digest_q[0].digest_word) begin
					$display("%0t: digest_word exp %h got %h", $time,
						digest_q[0].digest_word, rsp.digest_word);
					errors++;
				end
				if (rsp.word_index !== digest_q[0].word_index) begin
					$display("%0t: word_index exp %0d got %0d", $time,
						digest_q[0].word_index, rsp.word_index);
					errors++;
				end
				if (rsp.last_word !== digest_q[0].last_word) begin
					$display("%0t: last_word exp %b got %b", $time,
						digest_q[0].last_word, rsp.last_word);
					errors++;
				end
				if (rsp.misuse_error !== digest_q[0].misuse_error) begin
					$display("%0t: misuse_error exp %b got %b", $time,
						digest_q[0].misuse_error, rsp.misuse_error);
					errors++;
				end
				void'(digest_q.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (req_valid && issued_cnt != taken_cnt) begin
			end else begin
				if (req_valid) begin
					if ($urandom_range(0, 40) == 0)
						send_burst = !send_burst;
					send_gap = send_burst ? 0 : $urandom_range(0, 14);
				end
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					req <= pending_q.pop_front();
					req_valid <= 1'b1;
					issued_cnt++;
				end else begin
					req_valid <= 1'b0;
				end
			end
			if (word_cnt != words_seen) begin
				words_seen = word_cnt;
				if ($urandom_range(0, 20) == 0)
					sink_burst = !sink_burst;
				sink_stall = sink_burst ? 0 : $urandom_range(0, 14);
			end
			if (sink_stall > 0) begin
				sink_stall--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		int msg_len;
		int tail;
		int extra;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		issued_cnt = 0;
		taken_cnt = 0;
		word_cnt = 0;
		words_seen = 0;
		send_gap = 0;
		sink_stall = 0;
		send_burst = 1'b0;
		sink_burst = 1'b0;
		errors = 0;
		hash_w = H_START;
		for (int i = 0; i < 64; i++)
			blk[i] = 8'h00;
		fill = '0;
		byte_cnt = '0;
		finished = 1'b0;

		// pick the final block fill so padding hits its edge cases often
		case ($urandom_range(0, 6))
			0: tail = 0;
			1: tail = 1;
			2: tail = 55;
			3: tail = 56;
			4: tail = 57;
			5: tail = 63;
			default: tail = $urandom_range(0, 63);
		endcase
		msg_len = 64 * $urandom_range(4, 6) + tail;
		pending_q.push_back(mk(KIND_DATA, 8'h00));
		pending_q.push_back(mk(KIND_DATA, 8'hff));
		pending_q.push_back(mk(KIND_DATA, 8'h55));
		pending_q.push_back(mk(KIND_DATA, 8'haa));
		for (int i = 4; i < msg_len; i++)
			pending_q.push_back(mk(KIND_DATA, 8'($urandom_range(0, 255))));
		pending_q.push_back(mk(KIND_FINISH, 8'($urandom_range(0, 255))));
		pending_q.push_back(mk(KIND_DATA, 8'h00));
		pending_q.push_back(mk(KIND_DATA, 8'hff));
		pending_q.push_back(mk(KIND_FINISH, 8'h00));
		pending_q.push_back(mk(KIND_FINISH, 8'hff));
		extra = 500 - pending_q.size();
		if (extra < 60)
			extra = 60;
		for (int i = 0; i < extra; i++)
			pending_q.push_back(mk(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
		item_total = pending_q.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (taken_cnt == item_total && digest_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && digest_q.size() == 0)
			$display("sha256_stream_hasher_core_test passed");
		else
			$display("sha256_stream_hasher_core_test failed");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/sha_pkg.sv
hw/rtl/sha_ctrl.sv
hw/rtl/sha_dp.sv
hw/rtl/sha256_stream_hasher_core.sv
dv/sha256_stream_hasher_core_test.sv
